// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`endif
`endif

// ----- rtl/core/tcgit_pkg.sv -----
// types and constants of the greedy insertion two-tour unit
package tcgit_pkg;
    localparam int MAX_NODES = 32;
    localparam int DIST_BITS = 16;
    localparam int CITY_W    = 5;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_START_A    = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_INIT, OP_FAR_ISSUE, OP_FAR_EVAL, OP_B_INIT,
        OP_GROW_START, OP_PN_ISSUE, OP_PN_TAKE, OP_C_SKIP, OP_PC_ISSUE,
        OP_CN_ISSUE, OP_C_EVAL, OP_POS_NEXT, OP_SUCC_TAKE, OP_INS_A,
        OP_INS_B, OP_EMIT_START, OP_EMIT_LOAD, OP_EMIT_STEP, OP_EMIT_TAKE,
        OP_EMIT_SWITCH
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_FAR_RD, ST_FAR_EV, ST_B_INIT, ST_CHECK,
        ST_GROW, ST_PN_RD, ST_PN_TAKE, ST_CAND, ST_CN_RD, ST_C_EVAL,
        ST_POS_RD, ST_POS_TAKE, ST_INS_A, ST_INS_B, ST_EMIT_START,
        ST_EMIT_OUT, ST_EMIT_RD, ST_EMIT_TAKE, ST_EMIT_SW
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_en;
    } dp_cmd_t;

    typedef struct packed {
        logic             c_end;
        logic             c_visited;
        logic             pos_last;
        logic             all_visited;
        logic             out_busy;
        logic             emit_end;
        logic             emit_b;
        logic [CNT_W-1:0] visited_cnt;
        logic [CNT_W-1:0] n_eff;
    } dp_status_t;
endpackage

// ----- rtl/core/two_cycle_greedy_insertion_tour_unit.sv -----
// top level of the greedy insertion two-tour unit
// a load word is written into the distance memory; a run word does a farthest-city search,
// then an insertion search (two serial distance reads per unvisited city and position, none for
// a visited city, set by the single distance memory read port), then the output words
// n+2 output words per run; s_tready is low from the run word until the last word is loaded
// aresetn (sync, active low) clears control, node_count 32, start_node_a 0; distances undefined
`include "assert_macros.svh"
module two_cycle_greedy_insertion_tour_unit import tcgit_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // from_city[4:0], to_city[9:5], edge_length[25:10]
    input  logic                 s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // city[4:0]
    output logic                 m_tuser,   // tour_id
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);
    dp_cmd_t    cmd;
    dp_status_t st;
    logic [CITY_W-1:0] out_city;

    assign cfg_ready = 1'b1;

    // sequencer
    tcgit_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    tcgit_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .ld_from   (s_tdata[4:0]),
        .ld_to     (s_tdata[9:5]),
        .ld_len    (s_tdata[25:10]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_dat   (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_city  (out_city),
        .out_id    (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'b000, out_city};

    // checks
    `ASSERT_ALWAYS(a_cnt_le_n, aclk, aresetn, st.visited_cnt <= st.n_eff, "visited count above node count")
    `ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, cmd.op == OP_EMIT_LOAD, !m_tvalid, "output word overwritten")
    `ASSERT_IMPLY(a_idle_on_last, aclk, aresetn, m_tvalid && m_tlast, !cmd.load_en || s_tready, "last word while busy")
endmodule

// ----- rtl/core/tcgit_ctrl.sv -----
// sequencer for matrix load, tour construction and tour output
module tcgit_ctrl import tcgit_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_cmd,
    output logic       s_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);
    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_tvalid && s_cmd) state_next = ST_INIT;
            ST_INIT:       state_next = ST_FAR_RD;
            ST_FAR_RD:     state_next = st.c_end ? ST_B_INIT : ST_FAR_EV;
            ST_FAR_EV:     state_next = ST_FAR_RD;
            ST_B_INIT:     state_next = ST_CHECK;
            ST_CHECK:      state_next = st.all_visited ? ST_EMIT_START : ST_GROW;
            ST_GROW:       state_next = ST_PN_RD;
            ST_PN_RD:      state_next = ST_PN_TAKE;
            ST_PN_TAKE:    state_next = ST_CAND;
            ST_CAND: begin
                if (st.c_end) begin
                    state_next = st.pos_last ? ST_INS_A : ST_POS_RD;
                end else if (!st.c_visited) begin
                    state_next = ST_CN_RD;
                end
            end
            ST_CN_RD:      state_next = ST_C_EVAL;
            ST_C_EVAL:     state_next = ST_CAND;
            ST_POS_RD:     state_next = ST_POS_TAKE;
            ST_POS_TAKE:   state_next = ST_PN_RD;
            ST_INS_A:      state_next = ST_INS_B;
            ST_INS_B:      state_next = ST_CHECK;
            ST_EMIT_START: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (!st.out_busy) begin
                    if (!st.emit_end)   state_next = ST_EMIT_RD;
                    else if (st.emit_b) state_next = ST_IDLE;
                    else                state_next = ST_EMIT_SW;
                end
            end
            ST_EMIT_RD:    state_next = ST_EMIT_TAKE;
            ST_EMIT_TAKE:  state_next = ST_EMIT_OUT;
            ST_EMIT_SW:    state_next = ST_EMIT_OUT;
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd.op      = OP_NOP;
        cmd.load_en = 1'b0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_en = s_tvalid && !s_cmd;
            end
            ST_INIT:       cmd.op = OP_INIT;
            ST_FAR_RD:     if (!st.c_end) cmd.op = OP_FAR_ISSUE;
            ST_FAR_EV:     cmd.op = OP_FAR_EVAL;
            ST_B_INIT:     cmd.op = OP_B_INIT;
            ST_CHECK:      cmd.op = OP_NOP;
            ST_GROW:       cmd.op = OP_GROW_START;
            ST_PN_RD:      cmd.op = OP_PN_ISSUE;
            ST_PN_TAKE:    cmd.op = OP_PN_TAKE;
            ST_CAND: begin
                if (!st.c_end) cmd.op = st.c_visited ? OP_C_SKIP : OP_PC_ISSUE;
            end
            ST_CN_RD:      cmd.op = OP_CN_ISSUE;
            ST_C_EVAL:     cmd.op = OP_C_EVAL;
            ST_POS_RD:     cmd.op = OP_POS_NEXT;
            ST_POS_TAKE:   cmd.op = OP_SUCC_TAKE;
            ST_INS_A:      cmd.op = OP_INS_A;
            ST_INS_B:      cmd.op = OP_INS_B;
            ST_EMIT_START: cmd.op = OP_EMIT_START;
            ST_EMIT_OUT:   if (!st.out_busy) cmd.op = OP_EMIT_LOAD;
            ST_EMIT_RD:    cmd.op = OP_EMIT_STEP;
            ST_EMIT_TAKE:  cmd.op = OP_EMIT_TAKE;
            ST_EMIT_SW:    cmd.op = OP_EMIT_SWITCH;
            default:       cmd.op = OP_NOP;
        endcase
    end
endmodule

// ----- rtl/core/tcgit_datapath.sv -----
// distance memory, tour link memory, candidate search and output register
module tcgit_datapath import tcgit_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           st,
    input  logic [CITY_W-1:0]    ld_from,
    input  logic [CITY_W-1:0]    ld_to,
    input  logic [DIST_BITS-1:0] ld_len,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_DAT_W-1:0] cfg_dat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CITY_W-1:0]    out_city,
    output logic                 out_id,
    output logic                 out_last
);
    localparam int DADDR_W = 2 * CITY_W;
    localparam int SADDR_W = CITY_W + 1;

    // memories
    logic [DIST_BITS-1:0] dist_mem [2**DADDR_W];
    logic [CITY_W-1:0]    succ_mem [2**SADDR_W];

    logic [DIST_BITS-1:0] dist_rdata_reg;
    logic [CITY_W-1:0]    succ_rdata_reg;

    logic [CNT_W-1:0]     node_count_reg;
    logic [CITY_W-1:0]    start_a_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CITY_W-1:0]    sa_reg, sb_reg;
    logic [CITY_W-1:0]    head_a_reg, head_b_reg;
    logic [CNT_W-1:0]     len_a_reg, len_b_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 turn_reg;
    logic [CNT_W-1:0]     c_reg;
    logic [CITY_W-1:0]    pos_reg;
    logic [CITY_W-1:0]    prev_reg, nxt_reg;
    logic [DIST_BITS-1:0] e_pn_reg, e_pc_reg;
    logic                 found_reg;
    logic signed [DIST_BITS+1:0] best_d_reg;
    logic [CITY_W-1:0]    best_prev_reg, best_next_reg, best_city_reg;
    logic                 best_pos0_reg;
    logic                 have_far_reg;
    logic [DIST_BITS-1:0] far_reg;
    logic                 esel_reg;
    logic [CITY_W-1:0]    cur_reg;
    logic [CNT_W-1:0]     ei_reg;
    logic                 out_valid_reg;
    logic [CITY_W-1:0]    out_city_reg;
    logic                 out_id_reg, out_last_reg;

    logic [CNT_W-1:0]     n_calc;
    logic [CITY_W-1:0]    sa_calc;
    logic [CITY_W-1:0]    c_city;
    logic [CNT_W-1:0]     len_turn;
    logic [CITY_W-1:0]    head_turn;
    logic signed [DIST_BITS+1:0] delta;
    logic                 dist_re;
    logic [DADDR_W-1:0]   dist_raddr;
    logic                 succ_we, succ_re;
    logic [SADDR_W-1:0]   succ_waddr, succ_raddr;
    logic [CITY_W-1:0]    succ_wdata;

    // clamped node count and start city
    always_comb begin
        if (node_count_reg < CNT_W'(2))
            n_calc = CNT_W'(2);
        else if (node_count_reg > CNT_W'(MAX_NODES))
            n_calc = CNT_W'(MAX_NODES);
        else
            n_calc = node_count_reg;
        if ({1'b0, start_a_reg} >= n_calc)
            sa_calc = CITY_W'(n_calc - CNT_W'(1));
        else
            sa_calc = start_a_reg;
    end

    assign c_city    = c_reg[CITY_W-1:0];
    assign len_turn  = turn_reg ? len_b_reg : len_a_reg;
    assign head_turn = turn_reg ? head_b_reg : head_a_reg;

    // insertion delta: cost change of putting c between prev and next
    assign delta = $signed({2'b00, e_pc_reg}) + $signed({2'b00, dist_rdata_reg})
                 - $signed({2'b00, e_pn_reg});

    // distance memory read address
    always_comb begin
        dist_re    = 1'b1;
        dist_raddr = {prev_reg, nxt_reg};
        case (cmd.op)
            OP_FAR_ISSUE: dist_raddr = {sa_reg, c_city};
            OP_PN_ISSUE:  dist_raddr = {prev_reg, nxt_reg};
            OP_PC_ISSUE:  dist_raddr = {prev_reg, c_city};
            OP_CN_ISSUE:  dist_raddr = {c_city, nxt_reg};
            default:      dist_re    = 1'b0;
        endcase
    end

    // link memory ports
    always_comb begin
        succ_we    = 1'b1;
        succ_waddr = {1'b0, sa_calc};
        succ_wdata = sa_calc;
        case (cmd.op)
            OP_INIT: begin
                succ_waddr = {1'b0, sa_calc};
                succ_wdata = sa_calc;
            end
            OP_B_INIT: begin
                succ_waddr = {1'b1, sb_reg};
                succ_wdata = sb_reg;
            end
            OP_INS_A: begin
                succ_waddr = {turn_reg, best_prev_reg};
                succ_wdata = best_city_reg;
            end
            OP_INS_B: begin
                succ_waddr = {turn_reg, best_city_reg};
                succ_wdata = best_next_reg;
            end
            default: succ_we = 1'b0;
        endcase
        succ_re    = 1'b1;
        succ_raddr = {turn_reg, nxt_reg};
        case (cmd.op)
            OP_POS_NEXT:  succ_raddr = {turn_reg, nxt_reg};
            OP_EMIT_STEP: succ_raddr = {esel_reg, cur_reg};
            default:      succ_re    = 1'b0;
        endcase
    end

    // distance memory
    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            dist_mem[{ld_from, ld_to}] <= ld_len;
        end
        if (dist_re) begin
            dist_rdata_reg <= dist_mem[dist_raddr];
        end
    end

    // link memory
    always_ff @(posedge aclk) begin
        if (succ_we) begin
            succ_mem[succ_waddr] <= succ_wdata;
        end
        if (succ_re) begin
            succ_rdata_reg <= succ_mem[succ_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CNT_W'(MAX_NODES);
            start_a_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_NODE_COUNT: node_count_reg <= cfg_dat;
                CFG_START_A:    start_a_reg    <= cfg_dat[CITY_W-1:0];
                default:        ;
            endcase
        end
    end

    // tour state and visited bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= CNT_W'(MAX_NODES);
            cnt_reg     <= '0;
            visited_reg <= '0;
            len_a_reg   <= '0;
            len_b_reg   <= '0;
            turn_reg    <= 1'b0;
        end else begin
            case (cmd.op)
                OP_INIT: begin
                    n_reg       <= n_calc;
                    sa_reg      <= sa_calc;
                    head_a_reg  <= sa_calc;
                    len_a_reg   <= CNT_W'(1);
                    visited_reg <= MAX_NODES'(1) << sa_calc;
                    cnt_reg     <= CNT_W'(1);
                    turn_reg    <= 1'b0;
                end
                OP_B_INIT: begin
                    head_b_reg  <= sb_reg;
                    len_b_reg   <= CNT_W'(1);
                    visited_reg <= visited_reg | (MAX_NODES'(1) << sb_reg);
                    cnt_reg     <= cnt_reg + CNT_W'(1);
                end
                OP_INS_B: begin
                    visited_reg <= visited_reg | (MAX_NODES'(1) << best_city_reg);
                    cnt_reg     <= cnt_reg + CNT_W'(1);
                    if (turn_reg) begin
                        len_b_reg <= len_b_reg + CNT_W'(1);
                        if (best_pos0_reg) head_b_reg <= best_city_reg;
                    end else begin
                        len_a_reg <= len_a_reg + CNT_W'(1);
                        if (best_pos0_reg) head_a_reg <= best_city_reg;
                    end
                    turn_reg <= !turn_reg;
                end
                default: ;
            endcase
        end
    end

    // farthest-city search and insertion candidate search
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_INIT: begin
                c_reg        <= '0;
                have_far_reg <= 1'b0;
            end
            OP_FAR_EVAL: begin
                if (!visited_reg[c_city]) begin
                    if (!have_far_reg || dist_rdata_reg > far_reg) begin
                        have_far_reg <= 1'b1;
                        far_reg      <= dist_rdata_reg;
                        sb_reg       <= c_city;
                    end
                end
                c_reg <= c_reg + CNT_W'(1);
            end
            OP_GROW_START: begin
                prev_reg  <= turn_reg ? sb_reg : sa_reg;
                nxt_reg   <= head_turn;
                pos_reg   <= '0;
                found_reg <= 1'b0;
            end
            OP_PN_TAKE: begin
                e_pn_reg <= dist_rdata_reg;
                c_reg    <= '0;
            end
            OP_C_SKIP: c_reg <= c_reg + CNT_W'(1);
            OP_CN_ISSUE: e_pc_reg <= dist_rdata_reg;
            OP_C_EVAL: begin
                if (!found_reg || delta < best_d_reg) begin
                    found_reg     <= 1'b1;
                    best_d_reg    <= delta;
                    best_prev_reg <= prev_reg;
                    best_next_reg <= nxt_reg;
                    best_city_reg <= c_city;
                    best_pos0_reg <= (pos_reg == '0);
                end
                c_reg <= c_reg + CNT_W'(1);
            end
            OP_POS_NEXT: begin
                pos_reg  <= pos_reg + CITY_W'(1);
                prev_reg <= nxt_reg;
            end
            OP_SUCC_TAKE: nxt_reg <= succ_rdata_reg;
            default: ;
        endcase
    end

    // tour walk for output
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_EMIT_START: begin
                esel_reg <= 1'b0;
                cur_reg  <= head_a_reg;
                ei_reg   <= '0;
            end
            OP_EMIT_SWITCH: begin
                esel_reg <= 1'b1;
                cur_reg  <= head_b_reg;
                ei_reg   <= '0;
            end
            OP_EMIT_STEP: ei_reg  <= ei_reg + CNT_W'(1);
            OP_EMIT_TAKE: cur_reg <= succ_rdata_reg;
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT_LOAD) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.op == OP_EMIT_LOAD) begin
            out_city_reg <= cur_reg;
            out_id_reg   <= esel_reg;
            out_last_reg <= esel_reg && st.emit_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_city  = out_city_reg;
    assign out_id    = out_id_reg;
    assign out_last  = out_last_reg;

    // status to the sequencer
    assign st.c_end       = (c_reg == n_reg);
    assign st.c_visited   = visited_reg[c_city];
    assign st.pos_last    = ({1'b0, pos_reg} + CNT_W'(1) == len_turn);
    assign st.all_visited = (cnt_reg == n_reg);
    assign st.out_busy    = out_valid_reg;
    assign st.emit_end    = (ei_reg == (esel_reg ? len_b_reg : len_a_reg));
    assign st.emit_b      = esel_reg;
    assign st.visited_cnt = cnt_reg;
    assign st.n_eff       = n_reg;
endmodule

// ----- bench/two_cycle_greedy_insertion_tour_unit_tb.sv -----
// testbench of the greedy insertion two-tour unit: matrix loads, runs and tour checks
`timescale 1ns / 100ps
module two_cycle_greedy_insertion_tour_unit_tb;
    import tcgit_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int FILL_NODES  = 10;

    typedef enum int {ROW_CFG, ROW_LOAD, ROW_RUN} row_kind_t;

    typedef struct packed {
        logic       tour_id;
        logic [4:0] city;
        logic       last;
    } tour_word_t;

    typedef struct {
        row_kind_t kind;
        cfg_idx_t  idx;
        int        value;
        int        from_c;
        int        to_c;
        int        len;
        bit        typed;
        int        city_a;
        int        city_b;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // predictor copy of the block
    logic [15:0] dist_mem [MAX_NODES][MAX_NODES];
    int          node_cfg;
    int          start_cfg;
    int          tours [2][MAX_NODES];
    int          tour_len [2];
    bit          visited [MAX_NODES];

    tour_word_t  tour_words_q [$];
    int          err_count;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    stim_row_t   rows [$];

    two_cycle_greedy_insertion_tour_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    // receiver: random stalls and compare each accepted word
    always @(posedge aclk) begin
        tour_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tour_words_q.size() == 0) begin
                report_mismatch("unexpected word city", m_tdata[4:0], -1);
            end else begin
                want = tour_words_q.pop_front();
                if (m_tuser !== want.tour_id) report_mismatch("tour_id", m_tuser, want.tour_id);
                if (m_tdata[4:0] !== want.city) report_mismatch("city", m_tdata[4:0], want.city);
                if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic longint unsigned hop(input int a, input int b);
        return longint'(dist_mem[a][b]);
    endfunction

    function automatic bit all_cities_visited(input int n);
        for (int c = 0; c < n; c++)
            if (!visited[c]) return 1'b0;
        return 1'b1;
    endfunction

    // cheapest insertion into one tour, position-major, first best kept
    function automatic bit grow_tour(input int t, input int n);
        int l;
        int prev;
        int next;
        int best_pos;
        int best_city;
        bit found;
        longint unsigned base;
        longint unsigned cost;
        longint unsigned best;
        l = tour_len[t];
        base = 0;
        found = 1'b0;
        best = '1;
        best_pos = 0;
        best_city = 0;
        for (int k = 0; k + 1 < l; k++) base += hop(tours[t][k], tours[t][k+1]);
        base += hop(tours[t][l-1], tours[t][0]);
        for (int pos = 0; pos <= l; pos++) begin
            prev = (pos == 0 || pos == l) ? tours[t][l-1] : tours[t][pos-1];
            next = (pos == l) ? tours[t][0] : tours[t][pos];
            for (int c = 0; c < n; c++) begin
                if (!visited[c]) begin
                    cost = base - hop(prev, next) + hop(prev, c) + hop(c, next);
                    if (!found || cost < best) begin
                        found = 1'b1;
                        best = cost;
                        best_pos = pos;
                        best_city = c;
                    end
                end
            end
        end
        if (!found || l >= MAX_NODES) return 1'b0;
        for (int i = l; i > best_pos; i--) tours[t][i] = tours[t][i-1];
        tours[t][best_pos] = best_city;
        tour_len[t] = l + 1;
        visited[best_city] = 1'b1;
        return 1'b1;
    endfunction

    // build both tours and queue the words they produce
    task automatic predict_tours();
        int n;
        int sa;
        int sb;
        bit have_b;
        longint unsigned far;
        tour_word_t w;
        n = node_cfg < 2 ? 2 : (node_cfg > MAX_NODES ? MAX_NODES : node_cfg);
        sa = start_cfg >= n ? n - 1 : start_cfg;
        sb = 0;
        have_b = 1'b0;
        far = 0;
        for (int c = 0; c < MAX_NODES; c++) visited[c] = 1'b0;
        tours[0][0] = sa;
        tour_len[0] = 1;
        visited[sa] = 1'b1;
        for (int c = 0; c < n; c++) begin
            if (!visited[c] && (!have_b || hop(sa, c) > far)) begin
                have_b = 1'b1;
                far = hop(sa, c);
                sb = c;
            end
        end
        tours[1][0] = sb;
        tour_len[1] = 1;
        visited[sb] = 1'b1;
        while (!all_cities_visited(n)) begin
            if (!grow_tour(0, n)) break;
            if (all_cities_visited(n)) break;
            if (!grow_tour(1, n)) break;
        end
        for (int t = 0; t < 2; t++) begin
            for (int i = 0; i <= tour_len[t]; i++) begin
                w.tour_id = t[0];
                w.city = (i == tour_len[t]) ? tours[t][0][4:0] : tours[t][i][4:0];
                w.last = (t == 1) && (i == tour_len[t]);
                tour_words_q.insert(tour_words_q.size(), w);
            end
        end
    endtask

    // send one input word; the predictor runs at acceptance
    task automatic send_word(input bit cmd, input int from_c, input int to_c, input int len);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, len[15:0], to_c[4:0], from_c[4:0]};
        do @(posedge aclk); while (!s_tready);
        if (cmd) predict_tours();
        else dist_mem[from_c][to_c] = len[15:0];
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tour_words_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DAT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_NODE_COUNT) node_cfg = value & 6'h3f;
        else start_cfg = value & 5'h1f;
        @(posedge aclk);
    endtask

    task automatic push_typed(input int a, input int b);
        tour_words_q.insert(tour_words_q.size(), tour_word_t'{1'b0, a[4:0], 1'b0});
        tour_words_q.insert(tour_words_q.size(), tour_word_t'{1'b0, a[4:0], 1'b0});
        tour_words_q.insert(tour_words_q.size(), tour_word_t'{1'b1, b[4:0], 1'b0});
        tour_words_q.insert(tour_words_q.size(), tour_word_t'{1'b1, b[4:0], 1'b1});
    endtask

    task automatic add_row(input row_kind_t kind, input cfg_idx_t idx, input int value,
                           input int f, input int t, input int len,
                           input bit typed, input int ca, input int cb);
        stim_row_t r;
        r = '{kind, idx, value, f, t, len, typed, ca, cb};
        rows.insert(rows.size(), r);
    endtask

    initial begin
        stim_row_t r;
        int pick;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NODE_COUNT;
        cfg_data = '0;
        err_count = 0;
        cycle_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        node_cfg = 32;
        start_cfg = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the corner of the matrix that runs use, so no run reads an unwritten entry
        for (int f = 0; f < FILL_NODES; f++)
            for (int t = 0; t < FILL_NODES; t++)
                send_word(1'b0, f, t, $urandom_range(65535));
        drain();

        // directed table: two-city runs typed in, the rest predicted
        add_row(ROW_CFG, CFG_NODE_COUNT, 2, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, CFG_START_A, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_LOAD, CFG_NODE_COUNT, 0, 0, 1, 65535, 0, 0, 0);
        add_row(ROW_LOAD, CFG_NODE_COUNT, 0, 1, 0, 0, 0, 0, 0);
        add_row(ROW_LOAD, CFG_NODE_COUNT, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_RUN, CFG_NODE_COUNT, 0, 0, 0, 0, 1, 0, 1);
        add_row(ROW_CFG, CFG_START_A, 31, 0, 0, 0, 0, 0, 0);
        add_row(ROW_RUN, CFG_NODE_COUNT, 0, 0, 0, 0, 1, 1, 0);
        add_row(ROW_CFG, CFG_NODE_COUNT, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_RUN, CFG_NODE_COUNT, 0, 0, 0, 0, 1, 1, 0);
        add_row(ROW_CFG, CFG_NODE_COUNT, 1, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, CFG_START_A, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_RUN, CFG_NODE_COUNT, 0, 0, 0, 0, 1, 0, 1);
        add_row(ROW_CFG, CFG_NODE_COUNT, 3, 0, 0, 0, 0, 0, 0);
        add_row(ROW_LOAD, CFG_NODE_COUNT, 0, 31, 31, 65535, 0, 0, 0);
        add_row(ROW_LOAD, CFG_NODE_COUNT, 0, 0, 2, 65535, 0, 0, 0);
        add_row(ROW_LOAD, CFG_NODE_COUNT, 0, 31, 0, 0, 0, 0, 0);
        add_row(ROW_RUN, CFG_NODE_COUNT, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, CFG_NODE_COUNT, FILL_NODES, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, CFG_START_A, 31, 0, 0, 0, 0, 0, 0);
        add_row(ROW_RUN, CFG_NODE_COUNT, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, CFG_NODE_COUNT, FILL_NODES - 1, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, CFG_START_A, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_RUN, CFG_NODE_COUNT, 0, 0, 0, 0, 0, 0, 0);
        foreach (rows[i]) begin
            r = rows[i];
            case (r.kind)
                ROW_CFG: begin
                    drain();
                    write_reg(r.idx, r.value);
                end
                ROW_LOAD: send_word(1'b0, r.from_c, r.to_c, r.len);
                default: begin
                    if (r.typed) begin
                        push_typed(r.city_a, r.city_b);
                        send_word(1'b1, 0, 0, 0);
                        tour_words_q = tour_words_q[0:3];
                    end else begin
                        send_word(1'b1, 0, 0, 0);
                    end
                end
            endcase
        end

        // random part in three idling phases, new settings per block
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 60 : 0;
            rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 16 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                drain();
                pick = $urandom_range(9);
                write_reg(CFG_NODE_COUNT, pick == 0 ? $urandom_range(1) :
                          $urandom_range(2, FILL_NODES));
                write_reg(CFG_START_A, $urandom_range(31));
                for (int k = 0; k < 16; k++) begin
                    if ($urandom_range(99) < 15) begin
                        send_word(1'b1, $urandom_range(31), $urandom_range(31),
                                  $urandom_range(65535));
                    end else begin
                        pick = $urandom_range(9);
                        send_word(1'b0, $urandom_range(31), $urandom_range(31),
                                  pick == 0 ? 0 : pick == 1 ? 65535 : $urandom_range(65535));
                    end
                    // hold off until the block has delivered everything
                    if (ph == 1 && blk == 1 && k == 10) drain();
                end
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (err_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- two_cycle_greedy_insertion_tour_unit.f -----
+incdir+rtl/core
rtl/core/tcgit_pkg.sv
rtl/core/tcgit_ctrl.sv
rtl/core/tcgit_datapath.sv
rtl/core/two_cycle_greedy_insertion_tour_unit.sv
bench/two_cycle_greedy_insertion_tour_unit_tb.sv
